// ----- rtl/rpsa_pkg.sv -----
// Shared types and constants of the radix partition scatter addresser.
// No dependencies; imported by the top level and rpsa_engine.
`timescale 1ns / 1ps
`default_nettype none

package rpsa_pkg;

  // Item modes
  localparam logic [1:0] MODE_COUNT    = 2'd0;
  localparam logic [1:0] MODE_FINALIZE = 2'd1;
  localparam logic [1:0] MODE_PLACE    = 2'd2;

  // Register indexes on the configuration port (paddr[2])
  localparam logic REG_PARTITIONS_IN_USE = 1'b0;
  localparam logic REG_WORKERS_IN_USE    = 1'b1;

  localparam logic [4:0] PARTITIONS_IN_USE_RESET = 5'd10;
  localparam logic [3:0] WORKERS_IN_USE_RESET    = 4'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  part_index;
    logic [2:0]  batch_index;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] key_out;
  } out_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_FIN_RD,
    ST_FIN_WR
  } eng_state_t;

endpackage

`default_nettype wire

// ----- rtl/radix_partition_scatter_addresser.sv -----
// Top level of the radix partition scatter addresser: configuration registers,
// index range check and the engine. Uses rpsa_pkg, rpsa_engine.
`timescale 1ns / 1ps
`default_nettype none

// A count or place item reads its cell when idle, then writes it back with busy
// high. A place result shows on out_result with out_valid for one cycle, the
// cycle after the write back; it cannot be stalled, so the receiver must take
// it then. A finalize item walks the np*nw used cells, a read and a write state
// each, with busy high, np and nw being the effective partition and worker
// counts. Out-of-range count or place items and unused modes are dropped
// without going busy. After reset, busy stays high for a clearing pass over
// PARTITIONS * 2^max(1, ceil(log2(WORKERS))) cells (128 at the defaults) that
// zeroes both memories; configuration writes are taken during it.
module radix_partition_scatter_addresser #(
  parameter int PARTITIONS = 16,
  parameter int WORKERS    = 8,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire rpsa_pkg::in_item_t    in_item,
  output logic                       busy,
  output logic                       out_valid,
  output rpsa_pkg::out_result_t      out_result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import rpsa_pkg::*;

  localparam int NPB = $clog2(PARTITIONS + 1);
  localparam int NWB = $clog2(WORKERS + 1);
  localparam int PCW = (NPB > 5) ? NPB : 5;
  localparam int WCW = (NWB > 4) ? NWB : 4;

  logic [4:0] parts_cfg_r;
  logic [3:0] workers_cfg_r;
  logic       cfg_wr;

  logic [PCW-1:0] parts_ext, np;
  logic [WCW-1:0] workers_ext, nw;
  logic           item_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parts_cfg_r   <= PARTITIONS_IN_USE_RESET;
      workers_cfg_r <= WORKERS_IN_USE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PARTITIONS_IN_USE: parts_cfg_r   <= pwdata[4:0];
        REG_WORKERS_IN_USE:    workers_cfg_r <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PARTITIONS_IN_USE: prdata = {27'd0, parts_cfg_r};
      REG_WORKERS_IN_USE:    prdata = {28'd0, workers_cfg_r};
      default:               prdata = '0;
    endcase
  end

  // zero acts as one, large values saturate to the built-in size
  assign parts_ext   = PCW'(parts_cfg_r);
  assign workers_ext = WCW'(workers_cfg_r);
  assign np = (parts_ext == '0) ? PCW'(1) :
              (parts_ext > PCW'(PARTITIONS)) ? PCW'(PARTITIONS) : parts_ext;
  assign nw = (workers_ext == '0) ? WCW'(1) :
              (workers_ext > WCW'(WORKERS)) ? WCW'(WORKERS) : workers_ext;

  assign item_ok = (PCW'(in_item.part_index) < np) && (WCW'(in_item.batch_index) < nw);

  rpsa_engine #(
    .PARTITIONS (PARTITIONS),
    .WORKERS    (WORKERS),
    .COUNT_BITS (COUNT_BITS),
    .PCW        (PCW),
    .WCW        (WCW)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .item_ok    (item_ok),
    .np         (np),
    .nw         (nw),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // A valid place transfer yields its result after the RMW state, from the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && item_ok && in_item.mode == MODE_PLACE) |-> ##2 out_valid)
    else $error("place item produced no result");

  // Results only follow a read-modify-write, which holds busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // Two results are never back to back.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back results");

  // Count and finalize items never produce a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_COUNT || in_item.mode == MODE_FINALIZE))
      |-> ##2 !out_valid)
    else $error("result from count or finalize item");

endmodule

`default_nettype wire

// ----- rtl/rpsa_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpsa_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rpsa_engine.sv -----
// Sequencer of the addresser: clear pass, count/place read-modify-write and the
// finalize walk over the cell and partition start memories. Uses rpsa_pkg, rpsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module rpsa_engine #(
  parameter int PARTITIONS = 16,
  parameter int WORKERS    = 8,
  parameter int COUNT_BITS = 32,
  parameter int PCW        = 5,
  parameter int WCW        = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire rpsa_pkg::in_item_t    in_item,
  input  wire logic                  item_ok,
  input  wire logic [PCW-1:0]        np,
  input  wire logic [WCW-1:0]        nw,
  output logic                       busy,
  output logic                       out_valid,
  output rpsa_pkg::out_result_t      out_result
);

  import rpsa_pkg::*;

  localparam int PAW        = $clog2(PARTITIONS);
  localparam int WAW        = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CAW        = PAW + WAW;
  localparam int CELL_DEPTH = PARTITIONS * (2 ** WAW);

  eng_state_t state_r, state_nxt;
  in_item_t   item_r, item_nxt;
  logic [CAW-1:0]        clr_r, clr_nxt;
  logic [PAW-1:0]        fin_p_r, fin_p_nxt;
  logic [WAW-1:0]        fin_w_r, fin_w_nxt;
  logic [COUNT_BITS-1:0] run_r, run_nxt;
  logic [31:0]           start_r, start_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_result_t           out_r, out_nxt;

  logic                  cell_we;
  logic [CAW-1:0]        cell_waddr, cell_raddr;
  logic [COUNT_BITS-1:0] cell_wdata, cell_rdata;
  logic                  st_we;
  logic [PAW-1:0]        st_waddr, st_raddr;
  logic [31:0]           st_wdata, st_rdata;

  logic                  accept;
  logic                  clr_last, w_last, p_last;
  logic [COUNT_BITS-1:0] run_sum;
  logic [CAW-1:0]        item_cell;

  assign accept    = start && (state_r == ST_IDLE);
  assign clr_last  = (clr_r == CAW'(CELL_DEPTH - 1));
  assign w_last    = ((WCW'(fin_w_r) + WCW'(1)) == nw);
  assign p_last    = ((PCW'(fin_p_r) + PCW'(1)) == np);
  assign run_sum   = run_r + cell_rdata;
  assign item_cell = {PAW'(item_r.part_index), WAW'(item_r.batch_index)};

  rpsa_ram #(.W(COUNT_BITS), .DEPTH(CELL_DEPTH)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  rpsa_ram #(.W(32), .DEPTH(PARTITIONS)) u_starts (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_FINALIZE) begin
            state_nxt = ST_FIN_RD;
          end else if (item_ok &&
                       (in_item.mode == MODE_COUNT || in_item.mode == MODE_PLACE)) begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_RMW:    state_nxt = ST_IDLE;
      ST_FIN_RD: state_nxt = ST_FIN_WR;
      ST_FIN_WR: state_nxt = (w_last && p_last) ? ST_IDLE : ST_FIN_RD;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Memory controls, counters and result
  always_comb begin
    busy          = (state_r != ST_IDLE);
    item_nxt      = item_r;
    clr_nxt       = clr_r;
    fin_p_nxt     = fin_p_r;
    fin_w_nxt     = fin_w_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cell_we       = 1'b0;
    cell_waddr    = clr_r;
    cell_wdata    = '0;
    cell_raddr    = {fin_p_r, fin_w_r};
    st_we         = 1'b0;
    st_waddr      = clr_r[CAW-1:WAW];
    st_wdata      = '0;
    st_raddr      = PAW'(in_item.part_index);
    case (state_r)
      ST_CLEAR: begin
        // each start entry is zeroed once per worker column
        cell_we = 1'b1;
        st_we   = 1'b1;
        clr_nxt = clr_r + CAW'(1);
      end
      ST_IDLE: begin
        cell_raddr = {PAW'(in_item.part_index), WAW'(in_item.batch_index)};
        if (accept) begin
          item_nxt  = in_item;
          fin_p_nxt = '0;
          fin_w_nxt = '0;
          run_nxt   = '0;
          start_nxt = '0;
        end
      end
      ST_RMW: begin
        cell_we    = 1'b1;
        cell_waddr = item_cell;
        cell_wdata = cell_rdata + COUNT_BITS'(1);
        if (item_r.mode == MODE_PLACE) begin
          out_valid_nxt    = 1'b1;
          out_nxt.position = st_rdata + 32'(cell_rdata);
          out_nxt.key_out  = item_r.key;
        end
      end
      ST_FIN_RD: begin
      end
      ST_FIN_WR: begin
        cell_we    = 1'b1;
        cell_waddr = {fin_p_r, fin_w_r};
        cell_wdata = run_r;
        if (w_last) begin
          st_we     = 1'b1;
          st_waddr  = fin_p_r;
          st_wdata  = start_r;
          start_nxt = start_r + 32'(run_sum);
          run_nxt   = '0;
          fin_w_nxt = '0;
          fin_p_nxt = fin_p_r + PAW'(1);
        end else begin
          run_nxt   = run_sum;
          fin_w_nxt = fin_w_r + WAW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    fin_p_r <= fin_p_nxt;
    fin_w_r <= fin_w_nxt;
    run_r   <= run_nxt;
    start_r <= start_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

`default_nettype wire
